[rtl/ihg_pkg.sv]
// Shared types and constants for the IPv4 header generator.
`timescale 1ns / 1ps
`default_nettype none
package ihg_pkg;

  // Header geometry
  localparam int unsigned HdrBytes          = 20;
  localparam int unsigned IdxW              = $clog2(HdrBytes);
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [7:0]  VersionIhl = 8'h45;
  localparam logic [7:0]  TtlReset   = 8'd64;
  localparam logic [15:0] HdrLen     = 16'(HdrBytes);
  localparam logic [15:0] WordMask   = 16'hFFFF;

  // Checksum accumulator: seven 16-bit words fit in 19 bits
  localparam int unsigned AccW = 19;

  typedef logic [IdxW-1:0] hdr_idx_t;

  // Header byte positions
  localparam hdr_idx_t ByteVerIhl  = hdr_idx_t'(0);
  localparam hdr_idx_t ByteTotHi   = hdr_idx_t'(2);
  localparam hdr_idx_t ByteTotLo   = hdr_idx_t'(3);
  localparam hdr_idx_t ByteTtl     = hdr_idx_t'(8);
  localparam hdr_idx_t ByteProto   = hdr_idx_t'(9);
  localparam hdr_idx_t ByteCksHi   = hdr_idx_t'(10);
  localparam hdr_idx_t ByteCksLo   = hdr_idx_t'(11);
  localparam hdr_idx_t ByteSrc0    = hdr_idx_t'(12);
  localparam hdr_idx_t ByteSrc1    = hdr_idx_t'(13);
  localparam hdr_idx_t ByteSrc2    = hdr_idx_t'(14);
  localparam hdr_idx_t ByteSrc3    = hdr_idx_t'(15);
  localparam hdr_idx_t ByteDst0    = hdr_idx_t'(16);
  localparam hdr_idx_t ByteDst1    = hdr_idx_t'(17);
  localparam hdr_idx_t ByteDst2    = hdr_idx_t'(18);
  localparam hdr_idx_t ByteDst3    = hdr_idx_t'(19);
  localparam hdr_idx_t ByteLast    = hdr_idx_t'(HdrBytes - 1);

  // Checksum schedule: one step per header byte sent
  localparam hdr_idx_t StepTotal    = hdr_idx_t'(1);
  localparam hdr_idx_t StepTtlProto = hdr_idx_t'(2);
  localparam hdr_idx_t StepSrcHi    = hdr_idx_t'(3);
  localparam hdr_idx_t StepSrcLo    = hdr_idx_t'(4);
  localparam hdr_idx_t StepDstHi    = hdr_idx_t'(5);
  localparam hdr_idx_t StepDstLo    = hdr_idx_t'(6);
  localparam hdr_idx_t StepFold1    = hdr_idx_t'(7);
  localparam hdr_idx_t StepFold2    = hdr_idx_t'(8);

  typedef enum logic {
    CMD_HEADER  = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_t;

  // One job for the back end: a whole header or a single payload byte
  typedef struct packed {
    logic        is_hdr;
    logic        last;    // header: payload empty; payload: final byte
    logic [7:0]  byte8;   // header: protocol; payload: data byte
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] total;
  } entry_t;

endpackage
`default_nettype wire

[rtl/ihg_if.sv]
// Channel interfaces: command input, byte output, configuration write.
`timescale 1ns / 1ps
`default_nettype none
interface ihg_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  protocol;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] payload_length;
  logic [7:0]  data_byte;

  modport source (output valid, command, protocol, source_address, dest_address,
                  payload_length, data_byte, input ready);
  modport sink   (input valid, command, protocol, source_address, dest_address,
                  payload_length, data_byte, output ready);
endinterface

interface ihg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

interface ihg_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/ihg_fifo.sv]
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module ihg_fifo #(
  parameter int unsigned Depth = ihg_pkg::QueueDepthDefault
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  input  ihg_pkg::entry_t     push_entry,
  output logic                full,
  input  wire                 pop,
  output logic                head_valid,
  output ihg_pkg::entry_t     head_entry
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  ihg_pkg::entry_t slot_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;

  assign full       = (count_r == CntFull);
  assign head_valid = (count_r != '0);
  assign head_entry = slot_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrMax) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrMax) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/ihg_front.sv]
// Front end: accepts commands, tracks the open packet, queues jobs.
`timescale 1ns / 1ps
`default_nettype none
module ihg_front (
  input  wire              clk,
  input  wire              rst_n,
  ihg_in_if.sink           in_chan,
  input  wire              q_full,
  output logic             push,
  output ihg_pkg::entry_t  push_entry
);
  logic        packet_open_r, packet_open_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic        accept;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;

  // Classify the transfer and update packet state
  always_comb begin
    packet_open_nxt = packet_open_r;
    remaining_nxt   = remaining_r;
    push            = 1'b0;
    push_entry.is_hdr = 1'b0;
    push_entry.last   = 1'b0;
    push_entry.byte8  = in_chan.data_byte;
    push_entry.src    = in_chan.source_address;
    push_entry.dst    = in_chan.dest_address;
    push_entry.total  = in_chan.payload_length + ihg_pkg::HdrLen;
    if (accept) begin
      unique case (ihg_pkg::cmd_t'(in_chan.command))
        ihg_pkg::CMD_HEADER: begin
          push              = 1'b1;
          push_entry.is_hdr = 1'b1;
          push_entry.byte8  = in_chan.protocol;
          push_entry.last   = (in_chan.payload_length == '0);
          packet_open_nxt   = (in_chan.payload_length != '0);
          remaining_nxt     = in_chan.payload_length;
        end
        ihg_pkg::CMD_PAYLOAD: begin
          if (!packet_open_r || remaining_r == '0) begin
            // no packet open: drop the byte
            packet_open_nxt = 1'b0;
          end else begin
            push            = 1'b1;
            push_entry.last = (remaining_r == 16'd1);
            remaining_nxt   = remaining_r - 16'd1;
            if (remaining_r == 16'd1) begin
              packet_open_nxt = 1'b0;
            end
          end
        end
        default: begin
          packet_open_nxt = packet_open_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_open_r <= 1'b0;
      remaining_r   <= '0;
    end else begin
      packet_open_r <= packet_open_nxt;
      remaining_r   <= remaining_nxt;
    end
  end
endmodule
`default_nettype wire

[rtl/ihg_back.sv]
// Back end: serializes headers with checksum, forwards payload, output register.
`timescale 1ns / 1ps
`default_nettype none
module ihg_back (
  input  wire              clk,
  input  wire              rst_n,
  ihg_cfg_if.sink          cfg_chan,
  input  wire              q_valid,
  input  ihg_pkg::entry_t  q_entry,
  output logic             pop,
  ihg_out_if.source        out_chan
);
  logic [7:0]              ttl_r;
  logic                    busy_r, busy_nxt;
  ihg_pkg::hdr_idx_t       idx_r, idx_nxt;
  ihg_pkg::entry_t         cur_r, cur_nxt;
  logic [ihg_pkg::AccW-1:0] acc_r, acc_nxt, acc_step;
  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              out_byte_r, out_byte_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [7:0]              hdr_byte;
  logic [15:0]             cks;
  logic                    advance;

  assign cfg_chan.ready   = 1'b1;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.last     = out_last_r;
  assign advance           = !out_valid_r || out_chan.ready;
  assign cks               = ~acc_r[15:0];

  // TTL register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= ihg_pkg::TtlReset;
    end else if (cfg_chan.valid) begin
      ttl_r <= cfg_chan.data;
    end
  end

  // Header byte select
  always_comb begin
    case (idx_r)
      ihg_pkg::ByteVerIhl: hdr_byte = ihg_pkg::VersionIhl;
      ihg_pkg::ByteTotHi:  hdr_byte = cur_r.total[15:8];
      ihg_pkg::ByteTotLo:  hdr_byte = cur_r.total[7:0];
      ihg_pkg::ByteTtl:    hdr_byte = ttl_r;
      ihg_pkg::ByteProto:  hdr_byte = cur_r.byte8;
      ihg_pkg::ByteCksHi:  hdr_byte = cks[15:8];
      ihg_pkg::ByteCksLo:  hdr_byte = cks[7:0];
      ihg_pkg::ByteSrc0:   hdr_byte = cur_r.src[31:24];
      ihg_pkg::ByteSrc1:   hdr_byte = cur_r.src[23:16];
      ihg_pkg::ByteSrc2:   hdr_byte = cur_r.src[15:8];
      ihg_pkg::ByteSrc3:   hdr_byte = cur_r.src[7:0];
      ihg_pkg::ByteDst0:   hdr_byte = cur_r.dst[31:24];
      ihg_pkg::ByteDst1:   hdr_byte = cur_r.dst[23:16];
      ihg_pkg::ByteDst2:   hdr_byte = cur_r.dst[15:8];
      ihg_pkg::ByteDst3:   hdr_byte = cur_r.dst[7:0];
      default:             hdr_byte = 8'h00;  // zero DSCP, ID, flags, fragment
    endcase
  end

  // Checksum: one word added per header byte, then two end-around folds.
  // Done by byte 8, ahead of the checksum bytes at 10 and 11.
  always_comb begin
    case (idx_r)
      ihg_pkg::StepTotal:    acc_step = acc_r + ihg_pkg::AccW'(cur_r.total);
      ihg_pkg::StepTtlProto: acc_step = acc_r + ihg_pkg::AccW'({ttl_r, cur_r.byte8});
      ihg_pkg::StepSrcHi:    acc_step = acc_r + ihg_pkg::AccW'(cur_r.src[31:16]);
      ihg_pkg::StepSrcLo:    acc_step = acc_r + ihg_pkg::AccW'(cur_r.src[15:0]);
      ihg_pkg::StepDstHi:    acc_step = acc_r + ihg_pkg::AccW'(cur_r.dst[31:16]);
      ihg_pkg::StepDstLo:    acc_step = acc_r + ihg_pkg::AccW'(cur_r.dst[15:0]);
      ihg_pkg::StepFold1,
      ihg_pkg::StepFold2:
        acc_step = ihg_pkg::AccW'(acc_r[15:0] & ihg_pkg::WordMask)
                 + ihg_pkg::AccW'(acc_r[ihg_pkg::AccW-1:16]);
      default:               acc_step = acc_r;
    endcase
  end

  // Job sequencing and output register load
  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    if (advance) begin
      out_valid_nxt = 1'b0;
      if (busy_r) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = hdr_byte;
        out_last_nxt  = (idx_r == ihg_pkg::ByteLast) && cur_r.last;
        acc_nxt       = acc_step;
        idx_nxt       = idx_r + 1'b1;
        if (idx_r == ihg_pkg::ByteLast) begin
          busy_nxt = 1'b0;
        end
      end else if (q_valid) begin
        pop           = 1'b1;
        out_valid_nxt = 1'b1;
        if (q_entry.is_hdr) begin
          // first header byte goes out while the job loads
          busy_nxt     = 1'b1;
          cur_nxt      = q_entry;
          idx_nxt      = ihg_pkg::ByteVerIhl + 1'b1;
          acc_nxt      = ihg_pkg::AccW'({ihg_pkg::VersionIhl, 8'h00});
          out_byte_nxt = ihg_pkg::VersionIhl;
          out_last_nxt = 1'b0;
        end else begin
          out_byte_nxt = q_entry.byte8;
          out_last_nxt = q_entry.last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    acc_r      <= acc_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end
endmodule
`default_nettype wire

[rtl/ipv4_header_generator_core.sv]
// Top level of the IPv4 header generator.
//
//   channel   dir  payload                                               transfer when
//   in_chan   in   command, protocol, source_address, dest_address,      valid && ready
//                  payload_length, data_byte
//   out_chan  out  out_byte, last                                        valid && ready
//   cfg_chan  in   data (time_to_live)                                   valid && ready
//
// A header command yields 20 output bytes, back to back while out_chan.ready is high;
// a payload byte yields one byte; payload streams at one byte a cycle unless stalled.
// The back-end serializer sets the rate; the job queue (QueueDepth entries) lets
// the front keep accepting while a header is being sent.
// Payload bytes with no packet open are dropped by the front.
// Reset is synchronous, active low; TTL resets to 64. The output is registered and
// holds while out_chan.ready is low.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_header_generator_core #(
  parameter int unsigned QueueDepth = ihg_pkg::QueueDepthDefault
) (
  input  wire        clk,
  input  wire        rst_n,
  ihg_in_if.sink     in_chan,
  ihg_out_if.source  out_chan,
  ihg_cfg_if.sink    cfg_chan
);
  logic            push, pop, q_full, q_valid;
  ihg_pkg::entry_t push_entry, q_entry;

  ihg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ihg_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head_entry (q_entry)
  );

  ihg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .pop      (pop),
    .out_chan (out_chan)
  );
endmodule
`default_nettype wire

[test/ihg_packet_checker.sv]
// Checker for the IPv4 header generator: watches all channels and compares output bytes.
`timescale 1ns / 1ps
module ihg_packet_checker (
  input  wire clk,
  input  wire rst_n,
  ihg_in_if   in_mon,
  ihg_out_if  out_mon,
  ihg_cfg_if  cfg_mon,
  output int  fail_count,
  output int  bytes_pending,
  output int  header_count,
  output int  byte_count
);
  import ihg_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_byte_t;

  // Bytes the block still owes, oldest first
  pkt_byte_t   expected_packet_bytes[$];
  pkt_byte_t   oldest;
  logic [7:0]  ttl_q;
  logic [15:0] payload_left;
  logic        pkt_open;
  int          fails   = 0;
  int          headers = 0;
  int          checked = 0;

  // Build the 20 header bytes, checksum folded in, and queue them
  function automatic void queue_header(input logic [7:0] proto, input logic [31:0] src,
                                       input logic [31:0] dst, input logic [15:0] plen);
    logic [7:0]  hdr [HdrBytes];
    logic [15:0] total;
    logic [31:0] acc;
    logic [15:0] cks;
    total = plen + HdrLen;
    for (int i = 0; i < HdrBytes; i++) hdr[i] = 8'h00;
    hdr[0] = VersionIhl;
    hdr[2] = total[15:8];
    hdr[3] = total[7:0];
    hdr[8] = ttl_q;
    hdr[9] = proto;
    for (int i = 0; i < 4; i++) begin
      hdr[12 + i] = src[31 - 8 * i -: 8];
      hdr[16 + i] = dst[31 - 8 * i -: 8];
    end
    // ones'-complement sum of the ten words, end-around carry folded
    acc = '0;
    for (int i = 0; i < HdrBytes; i += 2) acc += {16'h0, hdr[i], hdr[i + 1]};
    while (acc[31:16] != 16'h0) acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    cks = ~acc[15:0];
    hdr[10] = cks[15:8];
    hdr[11] = cks[7:0];
    for (int i = 0; i < HdrBytes; i++)
      expected_packet_bytes.push_back('{data: hdr[i],
                                        last: (i == HdrBytes - 1) && (plen == 16'h0)});
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ttl_q        = TtlReset;
      payload_left = '0;
      pkt_open     = 1'b0;
      expected_packet_bytes.delete();
    end else begin
      // Output transfer: compare against the oldest expected byte
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (expected_packet_bytes.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected output byte %02h last %0b", $time,
                     out_mon.out_byte, out_mon.last);
        end else begin
          oldest = expected_packet_bytes.pop_front();
          if (oldest.data !== out_mon.out_byte || oldest.last !== out_mon.last) begin
            fails++;
            if (fails <= 10)
              $display("%0t: output mismatch: expected byte %02h last %0b, got %02h last %0b",
                       $time, oldest.data, oldest.last, out_mon.out_byte, out_mon.last);
          end
        end
      end

      // TTL register write
      if (cfg_mon.valid && cfg_mon.ready) ttl_q = cfg_mon.data;

      // Input transfer: predict what it produces
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CMD_HEADER) begin
          queue_header(in_mon.protocol, in_mon.source_address, in_mon.dest_address,
                       in_mon.payload_length);
          headers++;
          payload_left = in_mon.payload_length;
          pkt_open     = (in_mon.payload_length != 16'h0);
        end else if (pkt_open && payload_left != 16'h0) begin
          payload_left = payload_left - 16'h1;
          expected_packet_bytes.push_back('{data: in_mon.data_byte,
                                            last: (payload_left == 16'h0)});
          if (payload_left == 16'h0) pkt_open = 1'b0;
        end else begin
          // stray payload byte: dropped
          pkt_open = 1'b0;
        end
      end
    end
    fail_count    <= fails;
    bytes_pending <= expected_packet_bytes.size();
    header_count  <= headers;
    byte_count    <= checked;
  end
endmodule

[test/tb_ipv4_header_generator_core.sv]
// Testbench top for the IPv4 header generator: stimulus, handshake stalls and verdict.
`timescale 1ns / 1ps
module tb_ipv4_header_generator_core;
  import ihg_pkg::*;

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   items_sent;
  int   fail_count;
  int   bytes_pending;
  int   header_count;
  int   byte_count;

  ihg_in_if  in_chan ();
  ihg_out_if out_chan ();
  ihg_cfg_if cfg_chan ();

  ipv4_header_generator_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  ihg_packet_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_mon       (cfg_chan),
    .fail_count    (fail_count),
    .bytes_pending (bytes_pending),
    .header_count  (header_count),
    .byte_count    (byte_count)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: random back-pressure per current idle mix
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send_item(input cmd_t cmd, input logic [7:0] proto,
                           input logic [31:0] src, input logic [31:0] dst,
                           input logic [15:0] plen, input logic [7:0] dbyte);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.command        <= cmd;
    in_chan.protocol       <= proto;
    in_chan.source_address <= src;
    in_chan.dest_address   <= dst;
    in_chan.payload_length <= plen;
    in_chan.data_byte      <= dbyte;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    items_sent++;
  endtask

  // Header with a random (ignored) data byte
  task automatic send_header(input logic [7:0] proto, input logic [31:0] src,
                             input logic [31:0] dst, input logic [15:0] plen);
    send_item(CMD_HEADER, proto, src, dst, plen, 8'($urandom_range(255)));
  endtask

  // Payload byte with random (ignored) header fields
  task automatic send_payload(input logic [7:0] dbyte);
    send_item(CMD_PAYLOAD, 8'($urandom_range(255)), $urandom, $urandom,
              16'($urandom), dbyte);
  endtask

  // Drain all expected bytes, then let the block settle.
  // Wait on the clock first so the pending count includes the last input transfer.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_ttl(input logic [7:0] ttl);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= ttl;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // Random packets: mostly well-formed, some stray bytes and abandoned headers
  task automatic run_traffic(input int n_items);
    int stop_at;
    int pick;
    int sel;
    int len;
    int cut;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        sel = $urandom_range(99);
        if (sel < 15)      len = 0;
        else if (sel < 85) len = $urandom_range(8, 1);
        else if (sel < 97) len = $urandom_range(64, 9);
        else               len = $urandom_range(128, 65);
        cut = len;
        // occasionally cut short so the next header abandons it
        if (len > 1 && $urandom_range(9) == 0) cut = $urandom_range(len - 1);
        send_header(8'($urandom_range(255)), $urandom, $urandom, 16'(len));
        for (int k = 0; k < cut; k++) send_payload(8'($urandom_range(255)));
      end else if (pick < 90) begin
        repeat ($urandom_range(3, 1)) send_payload(8'($urandom_range(255)));
      end else begin
        send_header(8'($urandom_range(255)), $urandom, $urandom, 16'($urandom));
        repeat ($urandom_range(3)) send_payload(8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    items_sent             = 0;
    tx_idle_pct            = 23;
    rx_idle_pct            = 63;
    rst_n                  <= 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.command        <= CMD_HEADER;
    in_chan.protocol       <= '0;
    in_chan.source_address <= '0;
    in_chan.dest_address   <= '0;
    in_chan.payload_length <= '0;
    in_chan.data_byte      <= '0;
    cfg_chan.valid         <= 1'b0;
    cfg_chan.data          <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset TTL, empty payload, all-zero and all-one fields
    send_header(8'h00, 32'h0000_0000, 32'h0000_0000, 16'd0);
    send_header(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd3);
    send_payload(8'h00);
    send_payload(8'hFF);
    send_payload(8'hA5);
    // stray byte with no packet open
    send_payload(8'h5A);
    // header while a packet is open abandons it
    send_header(8'h06, 32'hC0A8_0001, 32'h0A00_0001, 16'd5);
    send_payload(8'h11);
    send_payload(8'h22);
    send_header(8'h11, 32'h7F00_0001, 32'hE000_0001, 16'd1);
    send_payload(8'h33);
    // oversized lengths: total length wraps
    send_header(8'h01, 32'h1234_5678, 32'h9ABC_DEF0, 16'hFFFF);
    send_payload(8'h44);
    send_payload(8'h55);
    send_header(8'h02, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 16'd65516);
    send_payload(8'h66);
    // largest legal length, total 0xFFFF
    send_header(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd65515);
    send_header(8'h11, 32'h0000_0000, 32'hFFFF_FFFF, 16'd1);
    send_payload(8'h77);
    // byte after the packet closed is dropped
    send_payload(8'h88);

    // Random phases, TTL changed only while idle
    wait_idle();
    write_ttl(8'h00);
    run_traffic(107);

    wait_idle();
    tx_idle_pct = 63;
    rx_idle_pct = 23;
    write_ttl(8'hFF);
    run_traffic(107);

    wait_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_ttl(8'($urandom_range(254, 1)));
    run_traffic(107);

    wait_idle();
    $display("Run covered %0d input transfers, %0d headers and %0d output bytes checked,",
             items_sent, header_count, byte_count);
    $display("with TTL at reset, 0, 255 and a mid value under three stall mixes.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

[ipv4_header_generator_core.f]
rtl/ihg_pkg.sv
rtl/ihg_if.sv
rtl/ihg_fifo.sv
rtl/ihg_front.sv
rtl/ihg_back.sv
rtl/ipv4_header_generator_core.sv
test/ihg_packet_checker.sv
test/tb_ipv4_header_generator_core.sv
